// File: rtl/core/smf_pkg.sv
// shared types and constants of the sliding window median filter
// no dependencies; used by every module of the block
package smf_pkg;

	localparam int LEN_BITS = 6;
	localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd5;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic raw;
		logic last_phase;
		logic out_busy;
	} stat_t;

endpackage

// File: rtl/core/smf_ctrl.sv
// controller state machine of the median filter
// depends on smf_pkg; drives the datapath through cmd_t, watches stat_t
module smf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  smf_pkg::stat_t stat,
	output smf_pkg::cmd_t  cmd
);
	import smf_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				state_nx = stat.raw ? ST_OUT : ST_SORT;
			end
			ST_SORT: begin
				if (stat.last_phase) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && s_tvalid;
		cmd.load     = (state_q == ST_LOAD);
		cmd.step     = (state_q == ST_SORT);
		cmd.out_load = (state_q == ST_OUT) && !stat.out_busy;
	end

endmodule

// File: rtl/core/smf_datapath.sv
// datapath of the median filter: sample line, fill count, sort cells, output register
// depends on smf_pkg; sequenced by smf_ctrl
module smf_datapath #(
	parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smf_pkg::cmd_t                   cmd,
	output smf_pkg::stat_t                  stat,
	input  logic signed [SAMPLE_BITS-1:0]   sample_in,
	input  logic                            cfg_we,
	input  logic [smf_pkg::LEN_BITS-1:0]    cfg_wdata,
	input  logic                            m_tready,
	output logic                            out_valid,
	output logic signed [SAMPLE_BITS-1:0]   filtered_out,
	output logic                            window_full
);
	import smf_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;
	localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_WINDOW);

	logic [LEN_BITS-1:0]           len_q;
	logic signed [SAMPLE_BITS-1:0] tap_q [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] key_q [MAX_WINDOW];
	logic                          pad_q [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] key_nx [MAX_WINDOW];
	logic                          pad_nx [MAX_WINDOW];
	logic [CNT_W-1:0]              fill_q, w_q, phase_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          raw_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_full_q;

	logic [CMP_W-1:0] len_ext, w_eff;
	logic [CNT_W-1:0] w_c, fill_next;
	logic [CNT_W:0]   fill_inc;
	logic [IDX_W-1:0] mid;

	// length zero acts as one, lengths past the line saturate
	always_comb begin
		len_ext   = CMP_W'(len_q);
		w_eff     = (len_ext == '0) ? CMP_W'(1) : ((len_ext > MAX_LEN) ? MAX_LEN : len_ext);
		w_c       = CNT_W'(w_eff);
		fill_inc  = {1'b0, fill_q} + (CNT_W + 1)'(1);
		fill_next = (fill_inc > {1'b0, w_c}) ? w_c : fill_inc[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.accept) begin
			fill_q <= fill_next;
		end
	end

	// newest sample at tap 0
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tap_q[0] <= sample_in;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
			sample_q <= sample_in;
			w_q      <= w_c;
			raw_q    <= (fill_next < w_c);
		end
	end

	// one odd-even transposition phase; padded cells rank above every sample
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			key_nx[i] = key_q[i];
			pad_nx[i] = pad_q[i];
		end
		for (int i = 0; i < MAX_WINDOW - 1; i++) begin
			if (1'(i % 2) == phase_q[0]) begin
				if ((pad_q[i] && !pad_q[i+1]) ||
				    (!pad_q[i] && !pad_q[i+1] && (key_q[i] > key_q[i+1]))) begin
					key_nx[i]   = key_q[i+1];
					key_nx[i+1] = key_q[i];
					pad_nx[i]   = pad_q[i+1];
					pad_nx[i+1] = pad_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				key_q[i] <= tap_q[i];
				pad_q[i] <= (CNT_W'(i) >= w_q);
			end
		end else if (cmd.step) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				key_q[i] <= key_nx[i];
				pad_q[i] <= pad_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.load) begin
			phase_q <= '0;
		end else if (cmd.step) begin
			phase_q <= phase_q + CNT_W'(1);
		end
	end

	assign mid = IDX_W'(w_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= raw_q ? sample_q : key_q[mid];
			out_full_q <= !raw_q;
		end
	end

	always_comb begin
		stat.raw        = raw_q;
		stat.last_phase = (phase_q == w_q - CNT_W'(1));
		stat.out_busy   = out_valid_q && !m_tready;
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = out_data_q;
	assign window_full  = out_full_q;

endmodule

// File: rtl/core/sliding_window_median_filter.sv
// top level of the sliding window median filter
// depends on smf_pkg, smf_ctrl and smf_datapath
//
//  port group   dir  payload                          beat when
//  s_*          in   tdata: sample_in                 s_tvalid & s_tready
//  m_*          out  tdata: filtered_out, tuser: full m_tvalid & m_tready
//  cfg_*        in   window_length                    cfg_we
//
// one beat in work at a time: a raw pass-through (window still filling) goes ST_LOAD then ST_OUT;
// a median goes ST_LOAD, ST_SORT until w phases have run, then ST_OUT, w being window_length
// with zero read as one and capped at MAX_WINDOW; the odd-even transposition sort runs one phase per cycle.
// the next beat is taken while a finished result waits in the output register; a second
// result holds in ST_OUT with s_tready low until m_tready frees that register.
// arst_n clears the fill count (window empties) and sets window_length to 5.
module sliding_window_median_filter #(
	parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample_in
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // filtered_out
	output logic                                  m_tuser,  // window_full
	input  logic                                  cfg_we,
	input  logic [smf_pkg::LEN_BITS-1:0]          cfg_wdata
);
	import smf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	cmd_t  cmd;
	stat_t stat;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [SAMPLE_BITS-1:0] filtered_out;

	assign sample_in = s_tdata[SAMPLE_BITS-1:0];

	smf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smf_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample_in    (sample_in),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.m_tready     (m_tready),
		.out_valid    (m_tvalid),
		.filtered_out (filtered_out),
		.window_full  (m_tuser)
	);

	assign m_tdata = TDATA_W'($unsigned(filtered_out));

endmodule

// File: rtl/core/smf_checker.sv
// port-level checks of the median filter, bound to the top level
// depends on smf_pkg and sliding_window_median_filter
module smf_checker #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
	input logic                                   m_tuser
);

	logic [1:0] pending_q;
	logic       s_beat, m_beat;

	assign s_beat = s_tvalid && s_tready;
	assign m_beat = m_tvalid && m_tready;

	// beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(s_beat) - 2'(m_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_tready)
		else $error("input taken while a beat is still in work");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more than two beats held");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_beat |-> pending_q != 2'd0)
		else $error("result delivered without an input beat");

endmodule

bind sliding_window_median_filter smf_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_smf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
